>>> hw/rtl/c3sf_pkg.sv
package c3sf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int PART_W       = 11;   // one weighted column: -1020..1020
    localparam int SUM_W        = 13;   // three columns: -1020..2295

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd2;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic [MODE_W-1:0] KERNEL_BOX     = 2'd0;
    localparam logic [MODE_W-1:0] KERNEL_SOBEL_X = 2'd1;
    localparam logic [MODE_W-1:0] KERNEL_LAPLACE = 2'd2;

    localparam logic [1:0] COL_LEFT   = 2'd0;
    localparam logic [1:0] COL_CENTER = 2'd1;
    localparam logic [1:0] COL_RIGHT  = 2'd2;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } lb_word_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              top_ok;
        logic              bot_ok;
    } win_ctl_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
    } item_ctl_t;

    typedef struct packed {
        pix_t pixel;
        logic last;
    } res_t;

    // Weighted sum of one window column; unused mode code falls back to box.
    function automatic part_t col_sum(input logic [MODE_W-1:0] mode, input logic [1:0] col,
                                      input pix_t p0, input pix_t p1, input pix_t p2);
        part_t a;
        part_t b;
        part_t c;
        part_t s;
        part_t res;
        a = {3'b000, p0};
        b = {3'b000, p1};
        c = {3'b000, p2};
        s = a + (b <<< 1) + c;
        case (mode)
            KERNEL_SOBEL_X:
            begin
                case (col)
                    COL_LEFT:  res = -s;
                    COL_RIGHT: res = s;
                    default:   res = '0;
                endcase
            end
            KERNEL_LAPLACE:
            begin
                case (col)
                    COL_CENTER: res = a + c - (b <<< 2);
                    default:    res = b;
                endcase
            end
            default: res = a + b + c;
        endcase
        return res;
    endfunction

endpackage

>>> hw/rtl/conv3x3_saturating_filter_core.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------
// input    | in_valid / in_ready  | func, pixel_in
// output   | out_valid / out_ready| pixel_out, frame_last
// config   | cfg_wr_en            | cfg_index, cfg_wdata
//
// One item per clock while the output skid entry is free; a result passes the
// line-buffer read register, the column-cell sums and the final add/clamp.
// The first result of a frame comes from input transfer image_width + 2.
// Reset clears counters, valid flags and config; the line buffer needs no clearing.
// in_ready drops only while the output skid entry is occupied.
module conv3x3_saturating_filter_core #(
    parameter int MAX_WIDTH  = c3sf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3sf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [c3sf_pkg::PIX_W-1:0]        pixel_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [c3sf_pkg::PIX_W-1:0]        pixel_out,
    output logic                              frame_last,
    input  logic                              cfg_wr_en,
    input  logic [c3sf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c3sf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WE_W   = $clog2(MAX_WIDTH + 1);
    localparam int HE_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int WCMP_W = (WE_W > c3sf_pkg::WIDTH_REG_W) ? WE_W : c3sf_pkg::WIDTH_REG_W;
    localparam int HCMP_W = (HE_W > c3sf_pkg::HEIGHT_REG_W) ? HE_W : c3sf_pkg::HEIGHT_REG_W;

    // configuration
    logic [c3sf_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [c3sf_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [c3sf_pkg::MODE_W-1:0]       mode_reg;
    logic                              geom_wr;

    logic [WE_W-1:0]  w_eff;
    logic [HE_W-1:0]  h_eff;
    logic [COL_W:0]   w_eff_c;
    logic [ROW_W-1:0] h_r;
    logic [ROW_W-1:0] h_p1;

    // position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W:0]   col_inc;

    logic                  adv;
    logic                  in_fire;
    logic                  case_edge;
    logic                  case_body;
    c3sf_pkg::item_ctl_t   ctl_s0;
    c3sf_pkg::pix_t        pix_s0;

    // pipeline
    logic                  s1_valid_reg;
    c3sf_pkg::pix_t        s1_pix_reg;
    logic [COL_W-1:0]      s1_addr_reg;
    c3sf_pkg::item_ctl_t   s1_ctl_reg;
    logic                  s2_valid_reg;
    c3sf_pkg::item_ctl_t   s2_ctl_reg;
    logic                  s3_emit_reg;
    logic                  s3_last_reg;

    c3sf_pkg::lb_word_t    lb_rd;
    c3sf_pkg::lb_word_t    lb_wr;
    c3sf_pkg::col_t        new_col;
    c3sf_pkg::col_t        col_right;
    c3sf_pkg::col_t        col_center;
    c3sf_pkg::col_t        col_left_unused;
    c3sf_pkg::win_ctl_t    win_ctl;
    c3sf_pkg::part_t       part_left;
    c3sf_pkg::part_t       part_center;
    c3sf_pkg::part_t       part_right;
    c3sf_pkg::sum_t        sum;
    c3sf_pkg::res_t        res;
    c3sf_pkg::res_t        res_out;
    logic                  skid_full;

    // effective geometry: zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WE_W'(1);
        end
        else if (WCMP_W'(width_reg) > WCMP_W'(MAX_WIDTH))
        begin
            w_eff = WE_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WE_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = HE_W'(1);
        end
        else if (HCMP_W'(height_reg) > HCMP_W'(MAX_HEIGHT))
        begin
            h_eff = HE_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HE_W'(height_reg);
        end
    end

    assign w_eff_c = (COL_W + 1)'(w_eff);
    assign h_r     = ROW_W'(h_eff);
    assign h_p1    = h_r + ROW_W'(1);

    assign geom_wr = cfg_wr_en && ((cfg_index == c3sf_pkg::CFG_IDX_WIDTH)
                                   || (cfg_index == c3sf_pkg::CFG_IDX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= c3sf_pkg::WIDTH_RESET;
            height_reg <= c3sf_pkg::HEIGHT_RESET;
            mode_reg   <= c3sf_pkg::KERNEL_BOX;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                c3sf_pkg::CFG_IDX_WIDTH:  width_reg  <= cfg_wdata[c3sf_pkg::WIDTH_REG_W-1:0];
                c3sf_pkg::CFG_IDX_HEIGHT: height_reg <= cfg_wdata;
                c3sf_pkg::CFG_IDX_MODE:   mode_reg   <= cfg_wdata[c3sf_pkg::MODE_W-1:0];
                default:                  ;
            endcase
        end
    end

    assign adv      = !skid_full;
    assign in_ready = adv;
    assign in_fire  = in_valid && adv;

    // Item classification. The edge case closes the last column of the row two
    // back using the shifted-in window with no right neighbor.
    always_comb
    begin
        case_edge = (col_reg == '0) && (row_reg >= ROW_W'(2)) && (row_reg <= h_p1);
        case_body = (col_reg != '0) && (row_reg >= ROW_W'(1)) && (row_reg <= h_r);

        ctl_s0.emit     = case_edge || case_body;
        ctl_s0.last     = case_edge && (row_reg == h_p1);
        ctl_s0.left_ok  = case_edge ? (w_eff >= WE_W'(2)) : (col_reg >= COL_W'(2));
        ctl_s0.right_ok = !case_edge;
        ctl_s0.top_ok   = case_edge ? (row_reg >= ROW_W'(3)) : (row_reg >= ROW_W'(2));
        ctl_s0.bot_ok   = case_edge ? (row_reg <= h_r) : (row_reg < h_r);

        if ((func == c3sf_pkg::FUNC_PIXEL) && (row_reg < h_r))
        begin
            pix_s0 = pixel_in;
        end
        else
        begin
            pix_s0 = '0;
        end
    end

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + (COL_W + 1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (geom_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_fire)
        begin
            if (ctl_s0.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= w_eff_c)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_emit_reg  <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv)
            begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_emit_reg  <= s2_valid_reg && s2_ctl_reg.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (in_valid)
            begin
                s1_pix_reg  <= pix_s0;
                s1_addr_reg <= col_reg;
                s1_ctl_reg  <= ctl_s0;
            end
            s2_ctl_reg  <= s1_ctl_reg;
            s3_last_reg <= s2_ctl_reg.last;
        end
    end

    // upper gets the row one back, middle the row just arriving
    assign lb_wr.upper  = lb_rd.middle;
    assign lb_wr.middle = s1_pix_reg;

    c3sf_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (lb_rd),
        .wr_en   (adv && s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (lb_wr)
    );

    assign new_col.top = lb_rd.upper;
    assign new_col.mid = lb_rd.middle;
    assign new_col.bot = s1_pix_reg;

    assign win_ctl.mode   = mode_reg;
    assign win_ctl.top_ok = s2_ctl_reg.top_ok;
    assign win_ctl.bot_ok = s2_ctl_reg.bot_ok;

    c3sf_col_cell u_cell_right (
        .clk     (clk),
        .adv     (adv),
        .shift   (s1_valid_reg),
        .col_pos (c3sf_pkg::COL_RIGHT),
        .col_ok  (s2_ctl_reg.right_ok),
        .ctl     (win_ctl),
        .col_in  (new_col),
        .col_out (col_right),
        .part    (part_right)
    );

    c3sf_col_cell u_cell_center (
        .clk     (clk),
        .adv     (adv),
        .shift   (s1_valid_reg),
        .col_pos (c3sf_pkg::COL_CENTER),
        .col_ok  (1'b1),
        .ctl     (win_ctl),
        .col_in  (col_right),
        .col_out (col_center),
        .part    (part_center)
    );

    c3sf_col_cell u_cell_left (
        .clk     (clk),
        .adv     (adv),
        .shift   (s1_valid_reg),
        .col_pos (c3sf_pkg::COL_LEFT),
        .col_ok  (s2_ctl_reg.left_ok),
        .ctl     (win_ctl),
        .col_in  (col_center),
        .col_out (col_left_unused),
        .part    (part_left)
    );

    always_comb
    begin
        sum = c3sf_pkg::sum_t'(part_left) + c3sf_pkg::sum_t'(part_center)
            + c3sf_pkg::sum_t'(part_right);
        if (sum < 0)
        begin
            res.pixel = '0;
        end
        else if (sum > c3sf_pkg::sum_t'(255))
        begin
            res.pixel = '1;
        end
        else
        begin
            res.pixel = sum[c3sf_pkg::PIX_W-1:0];
        end
        res.last = s3_last_reg;
    end

    c3sf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv && s3_emit_reg),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_out),
        .full      (skid_full)
    );

    assign pixel_out  = res_out.pixel;
    assign frame_last = res_out.last;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < w_eff_c))
        else $error("column counter beyond row width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= h_p1))
        else $error("row counter beyond frame drain row");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ctl_s0.last) |=> ((col_reg == '0) && (row_reg == '0)))
        else $error("counters not cleared after last pixel of frame");

endmodule

>>> hw/rtl/c3sf_line_buf.sv
module c3sf_line_buf #(
    parameter int  DEPTH  = c3sf_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output c3sf_pkg::lb_word_t  rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  c3sf_pkg::lb_word_t  wr_data
);

    c3sf_pkg::lb_word_t mem [DEPTH];
    c3sf_pkg::lb_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first on a same-address collision (one-pixel-wide rows)
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/c3sf_col_cell.sv
module c3sf_col_cell (
    input  logic                clk,
    input  logic                adv,
    input  logic                shift,
    input  logic [1:0]          col_pos,
    input  logic                col_ok,
    input  c3sf_pkg::win_ctl_t  ctl,
    input  c3sf_pkg::col_t      col_in,
    output c3sf_pkg::col_t      col_out,
    output c3sf_pkg::part_t     part
);

    c3sf_pkg::col_t  pix_reg;
    c3sf_pkg::part_t part_reg;
    c3sf_pkg::pix_t  top_m;
    c3sf_pkg::pix_t  bot_m;
    c3sf_pkg::part_t part_next;

    always_comb
    begin
        top_m = ctl.top_ok ? pix_reg.top : '0;
        bot_m = ctl.bot_ok ? pix_reg.bot : '0;
        if (col_ok)
        begin
            part_next = c3sf_pkg::col_sum(ctl.mode, col_pos, top_m, pix_reg.mid, bot_m);
        end
        else
        begin
            part_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            part_reg <= part_next;
            if (shift)
            begin
                pix_reg <= col_in;
            end
        end
    end

    assign col_out = pix_reg;
    assign part    = part_reg;

endmodule

>>> hw/rtl/c3sf_out_buf.sv
module c3sf_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  c3sf_pkg::res_t   res_in,
    input  logic             out_ready,
    output logic             out_valid,
    output c3sf_pkg::res_t   res_out,
    output logic             full
);

    logic           out_valid_reg;
    logic           skid_valid_reg;
    c3sf_pkg::res_t out_data_reg;
    c3sf_pkg::res_t skid_data_reg;
    logic           take;

    assign take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || take)
        begin
            if (push)
            begin
                out_data_reg <= res_in;
            end
        end
        else if (push)
        begin
            skid_data_reg <= res_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_out   = out_data_reg;
    assign full      = skid_valid_reg;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled while output register was free");

endmodule
